// ===== hw/rtl/ksum_pkg.sv =====
// ----------------------------------------------------------------------------
// ksum_pkg: shared types and constants of the keyed sum table
// Command and status codes, field widths and the records that travel
// along the cell chain and into the cells on an insert.
// ----------------------------------------------------------------------------
package ksum_pkg;

  // default table depth
  localparam int ENTRIES_DEF = 32;

  // field widths
  localparam int CMD_W    = 2;
  localparam int KEY_H_W  = 64;
  localparam int KEY_L_W  = 48;
  localparam int UNIT_W   = 32;
  localparam int AMT_W    = 16;
  localparam int SLOT_W   = 5;
  localparam int STAT_W   = 3;
  localparam int TOTAL_W  = 24;
  localparam int SUM_W    = 25;

  // only this many slots can be addressed by a read or reported
  localparam int SLOT_LIMIT = 1 << SLOT_W;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // packed stream widths
  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 176;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_SUMMED     = 3'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STAT_W-1:0] ST_ZERO       = 3'd3;
  localparam logic [STAT_W-1:0] ST_READ_VALID = 3'd4;
  localparam logic [STAT_W-1:0] ST_READ_EMPTY = 3'd5;
  localparam logic [STAT_W-1:0] ST_CLEARED    = 3'd6;

  // search token handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic               is_read;
    logic [KEY_H_W-1:0] key_h;
    logic [KEY_L_W-1:0] key_l;
    logic [UNIT_W-1:0]  unit;
    logic [AMT_W-1:0]   amount;
    logic [SLOT_W-1:0]  read_slot;
    logic               found;
    logic [SLOT_W-1:0]  slot;
    logic [TOTAL_W-1:0] total;
  } tok_t;

  // insert write broadcast to all cells
  typedef struct packed {
    logic               we;
    logic [KEY_H_W-1:0] key_h;
    logic [KEY_L_W-1:0] key_l;
    logic [UNIT_W-1:0]  unit;
    logic [TOTAL_W-1:0] total;
  } ins_t;

  // one result transaction
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  slot;
    logic [TOTAL_W-1:0] total;
    logic [UNIT_W-1:0]  unit;
    logic [KEY_H_W-1:0] key_h;
    logic [KEY_L_W-1:0] key_l;
  } res_t;

endpackage

// ===== hw/rtl/ksum_cell.sv =====
// ----------------------------------------------------------------------------
// ksum_cell: one slot of the keyed sum table
// Holds key, unit and total of one slot, checks the passing search token
// against them, adds on a key match, copies out on a read and registers the
// token before handing it on to the next cell.
// ----------------------------------------------------------------------------
module ksum_cell #(
  parameter int IDX = 0,
  parameter int IW  = 5,
  parameter int CW  = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ksum_pkg::tok_t   tok_i,
  output ksum_pkg::tok_t   tok_o,
  input  logic [CW-1:0]    fill_i,
  input  ksum_pkg::ins_t   ins_i,
  input  logic [IW-1:0]    ins_idx_i
);
  import ksum_pkg::*;

  localparam logic [CW-1:0]     IDX_CNT  = CW'(IDX);
  localparam logic [IW-1:0]     IDX_ADR  = IW'(IDX);
  localparam logic [SLOT_W-1:0] IDX_SLOT = SLOT_W'(IDX);
  localparam bit                READABLE = (IDX < SLOT_LIMIT);

  logic [KEY_H_W-1:0] kh_r, kh_nxt;
  logic [KEY_L_W-1:0] kl_r, kl_nxt;
  logic [UNIT_W-1:0]  unit_r, unit_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  tok_t               tok_r, tok_nxt;

  logic               live;
  logic               key_hit;
  logic               read_hit;
  logic [SUM_W-1:0]   sum;
  logic [TOTAL_W-1:0] sat_total;

  // match checks against this slot
  always_comb begin
    live     = (IDX_CNT < fill_i);
    key_hit  = tok_i.valid && !tok_i.found && !tok_i.is_read && live &&
               (tok_i.key_h == kh_r) && (tok_i.key_l == kl_r);
    read_hit = tok_i.valid && !tok_i.found && tok_i.is_read && live &&
               READABLE && (tok_i.read_slot == IDX_SLOT);
  end

  // saturating add of the amount onto the stored total
  always_comb begin
    sum       = SUM_W'(total_r) + SUM_W'(tok_i.amount);
    sat_total = sum[SUM_W-1] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  end

  // token update
  always_comb begin
    tok_nxt = tok_i;
    if (key_hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.slot  = IDX_SLOT;
      tok_nxt.total = sat_total;
      tok_nxt.unit  = unit_r;
    end else if (read_hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.slot  = IDX_SLOT;
      tok_nxt.total = total_r;
      tok_nxt.unit  = unit_r;
      tok_nxt.key_h = kh_r;
      tok_nxt.key_l = kl_r;
    end
  end

  // slot contents: insert write or total update on a match
  always_comb begin
    kh_nxt    = kh_r;
    kl_nxt    = kl_r;
    unit_nxt  = unit_r;
    total_nxt = total_r;
    if (ins_i.we && (ins_idx_i == IDX_ADR)) begin
      kh_nxt    = ins_i.key_h;
      kl_nxt    = ins_i.key_l;
      unit_nxt  = ins_i.unit;
      total_nxt = ins_i.total;
    end else if (key_hit) begin
      total_nxt = sat_total;
    end
  end

  // slot storage, no reset
  always_ff @(posedge clk) begin
    kh_r    <= kh_nxt;
    kl_r    <= kl_nxt;
    unit_r  <= unit_nxt;
    total_r <= total_nxt;
  end

  // token register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ===== hw/rtl/keyed_sum_table.sv =====
// ----------------------------------------------------------------------------
// keyed_sum_table: group-by-sum table built as a chain of slot cells
// Adds amounts under a name key, inserts new keys, reads and clears slots.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  stream: one transaction per command (add, read slot, clear).
//         in_tuser carries the command, in_tdata key, unit, amount, slot.
//   out_* stream: one result transaction per add, read or clear; command
//         three is taken and dropped without a result.
//   Add and read send a search token down a chain of ENTRIES cells, one
//   cell per cycle; the result is settled when the token leaves the last
//   cell and goes through a pending register into the output register
//   before the next command is taken. A zero-amount add or a clear skips
//   the chain and goes straight to the pending register. One command is
//   in work at a time; the chain length sets the throughput.
//   A new command is taken while the last result still waits in the output
//   register; if the receiver stalls, the next result is held inside and
//   no further command is taken until the output register frees up.
//   Reset (rst_n low, synchronous) empties the table and the chain; slot
//   contents are not cleared, unfilled slots are never reported.
// ----------------------------------------------------------------------------
module keyed_sum_table #(
  parameter int ENTRIES = ksum_pkg::ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // fields from bit 0: key_high[63:0], key_low[111:64], unit_tag[143:112],
  // amount[159:144], read_slot[164:160], zero fill
  input  logic [ksum_pkg::IN_DATA_W-1:0]     in_tdata,
  // fields from bit 0: command[1:0]
  input  logic [ksum_pkg::CMD_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // fields from bit 0: slot[4:0], total[28:5], unit_out[60:29],
  // key_high_out[124:61], key_low_out[172:125], zero fill
  output logic [ksum_pkg::OUT_DATA_W-1:0]    out_tdata,
  // fields from bit 0: status[2:0]
  output logic [ksum_pkg::STAT_W-1:0]        out_tuser
);
  import ksum_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_DONE   = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  tok_t               head_r, head_nxt;
  res_t               pend_r, pend_nxt;
  res_t               out_r, out_nxt;
  logic               out_vld_r, out_vld_nxt;
  ins_t               ins;
  logic [IW-1:0]      ins_idx;
  tok_t               tok_w [ENTRIES+1];
  logic [ENTRIES-1:0] vld_vec;
  tok_t               tail;

  logic [CMD_W-1:0]   in_cmd;
  logic [KEY_H_W-1:0] in_key_h;
  logic [KEY_L_W-1:0] in_key_l;
  logic [UNIT_W-1:0]  in_unit;
  logic [AMT_W-1:0]   in_amount;
  logic [SLOT_W-1:0]  in_rslot;
  logic               in_acc;

  // input field unpacking
  assign in_cmd    = in_tuser;
  assign in_key_h  = in_tdata[63:0];
  assign in_key_l  = in_tdata[111:64];
  assign in_unit   = in_tdata[143:112];
  assign in_amount = in_tdata[159:144];
  assign in_rslot  = in_tdata[164:160];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // cell chain
  assign tok_w[0] = head_r;
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    ksum_cell #(
      .IDX (g),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tok_i     (tok_w[g]),
      .tok_o     (tok_w[g+1]),
      .fill_i    (fill_r),
      .ins_i     (ins),
      .ins_idx_i (ins_idx)
    );
    assign vld_vec[g] = tok_w[g+1].valid;
  end
  assign tail = tok_w[ENTRIES];

  // command control
  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    pend_nxt    = pend_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !out_tready;
    ins_idx     = IW'(fill_r);

    head_nxt           = '0;
    head_nxt.is_read   = (in_cmd == CMD_READ);
    head_nxt.key_h     = in_key_h;
    head_nxt.key_l     = in_key_l;
    head_nxt.unit      = in_unit;
    head_nxt.amount    = in_amount;
    head_nxt.read_slot = in_rslot;

    ins       = '0;
    ins.key_h = tail.key_h;
    ins.key_l = tail.key_l;
    ins.unit  = tail.unit;
    ins.total = TOTAL_W'(tail.amount);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_ADD: begin
              if (in_amount == '0) begin
                pend_nxt        = '0;
                pend_nxt.status = ST_ZERO;
                state_nxt       = S_DONE;
              end else begin
                head_nxt.valid = 1'b1;
                state_nxt      = S_SEARCH;
              end
            end
            CMD_READ: begin
              head_nxt.valid = 1'b1;
              state_nxt      = S_SEARCH;
            end
            CMD_CLEAR: begin
              fill_nxt        = '0;
              pend_nxt        = '0;
              pend_nxt.status = ST_CLEARED;
              state_nxt       = S_DONE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SEARCH: begin
        // token leaves the last cell: settle the result
        if (tail.valid) begin
          state_nxt = S_DONE;
          pend_nxt  = '0;
          if (tail.is_read) begin
            if (tail.found) begin
              pend_nxt.status = ST_READ_VALID;
              pend_nxt.slot   = tail.slot;
              pend_nxt.total  = tail.total;
              pend_nxt.unit   = tail.unit;
              pend_nxt.key_h  = tail.key_h;
              pend_nxt.key_l  = tail.key_l;
            end else begin
              pend_nxt.status = ST_READ_EMPTY;
              pend_nxt.slot   = tail.read_slot;
            end
          end else if (tail.found) begin
            pend_nxt.status = ST_SUMMED;
            pend_nxt.slot   = tail.slot;
            pend_nxt.total  = tail.total;
            pend_nxt.unit   = tail.unit;
            pend_nxt.key_h  = tail.key_h;
            pend_nxt.key_l  = tail.key_l;
          end else if (fill_r == FULL_CNT) begin
            pend_nxt.status = ST_FULL;
          end else begin
            ins.we          = 1'b1;
            fill_nxt        = fill_r + 1'b1;
            pend_nxt.status = ST_INSERTED;
            pend_nxt.slot   = SLOT_W'(fill_r);
            pend_nxt.total  = TOTAL_W'(tail.amount);
            pend_nxt.unit   = tail.unit;
            pend_nxt.key_h  = tail.key_h;
            pend_nxt.key_l  = tail.key_l;
          end
        end
      end
      S_DONE: begin
        // hand the result to the output register once it is free
        if (!out_vld_r || out_tready) begin
          out_nxt     = pend_r;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // head token register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r <= head_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  // output packing
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {3'b000, out_r.key_l, out_r.key_h, out_r.unit,
                       out_r.total, out_r.slot};

`ifndef SYNTHESIS
  // fill count never exceeds the table depth
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count above table depth");

  // exactly one search token lives in the chain while searching
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> $onehot({vld_vec, head_r.valid}))
    else $error("search token lost or duplicated");

  // no token in the chain outside a search
  a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SEARCH) |-> ({vld_vec, head_r.valid} == '0))
    else $error("stray search token");

  // a clear empties the table on the next cycle
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == CMD_CLEAR)) |=> (fill_r == '0))
    else $error("clear did not empty the table");
`endif

endmodule

// ===== test/keyed_sum_table_tb.sv =====
// ----------------------------------------------------------------------------
// keyed_sum_table_tb: self-checking bench for the group-by-sum table
// Drives add, read, clear and ignored commands on the input stream and holds
// its own copy of the table, so every result transaction is predicted at
// the moment its command is taken. Results are compared field by field in
// arrival order. Sender bursts and gaps, receiver stall patterns and a long
// receiver hold-off move the handshakes around the block's search cycles.
// ----------------------------------------------------------------------------
module keyed_sum_table_tb;
  import ksum_pkg::*;

  localparam int SLOTS      = ENTRIES_DEF;
  localparam int LATENCY    = SLOTS + 3;
  localparam int CYCLE_CAP  = 1000000;
  localparam int HOLD_LEN   = 400;
  localparam int PRINT_CAP  = 40;
  localparam int RANDOM_CNT = 990;

  // command code the block takes and drops without a result
  localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

  typedef enum {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [CMD_W-1:0]      in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;

  // predicted table contents
  logic [KEY_H_W-1:0] tally_key_h [SLOTS];
  logic [KEY_L_W-1:0] tally_key_l [SLOTS];
  logic [UNIT_W-1:0]  tally_unit  [SLOTS];
  logic [TOTAL_W-1:0] tally_total [SLOTS];
  int                 tally_fill = 0;

  res_t replies_due [$];
  int   mismatches   = 0;
  int   replies_seen = 0;
  int   items_sent   = 0;
  int   cycles       = 0;

  // sender pacing
  bit offering   = 1'b0;
  bit gaps_on    = 1'b1;
  int burst_left = 0;

  // each increment asks the receiver for one long hold-off
  int hold_asked = 0;

  keyed_sum_table #(
    .ENTRIES(SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, replies_due.size());
      $display("keyed_sum_table: mismatch");
      $finish;
    end
  end

  function automatic res_t slot_reply(input logic [STAT_W-1:0] status, input int s);
    res_t r;
    r.status = status;
    r.slot   = s[SLOT_W-1:0];
    r.total  = tally_total[s];
    r.unit   = tally_unit[s];
    r.key_h  = tally_key_h[s];
    r.key_l  = tally_key_l[s];
    return r;
  endfunction

  // updates the predicted table for one command, returns 1 if a result follows
  function automatic bit tally_apply(input logic [CMD_W-1:0] cmd,
                                     input logic [KEY_H_W-1:0] kh,
                                     input logic [KEY_L_W-1:0] kl,
                                     input logic [UNIT_W-1:0] unit,
                                     input logic [AMT_W-1:0] amt,
                                     input logic [SLOT_W-1:0] rs,
                                     output res_t r);
    logic [SUM_W-1:0] sum;
    int hit;
    r   = '0;
    hit = -1;
    case (cmd)
      CMD_ADD: begin
        if (amt == '0) begin
          r.status = ST_ZERO;
          return 1'b1;
        end
        // lowest matching slot wins
        for (int s = 0; s < tally_fill; s++)
          if (hit < 0 && tally_key_h[s] == kh && tally_key_l[s] == kl) hit = s;
        if (hit >= 0) begin
          sum = SUM_W'(tally_total[hit]) + SUM_W'(amt);
          tally_total[hit] = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
          r = slot_reply(ST_SUMMED, hit);
        end else if (tally_fill >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          tally_key_h[tally_fill] = kh;
          tally_key_l[tally_fill] = kl;
          tally_unit[tally_fill]  = unit;
          tally_total[tally_fill] = TOTAL_W'(amt);
          r = slot_reply(ST_INSERTED, tally_fill);
          tally_fill++;
        end
        return 1'b1;
      end
      CMD_READ: begin
        if (rs < tally_fill && rs < SLOTS) begin
          r = slot_reply(ST_READ_VALID, int'(rs));
        end else begin
          r.status = ST_READ_EMPTY;
          r.slot   = rs;
        end
        return 1'b1;
      end
      CMD_CLEAR: begin
        tally_fill = 0;
        r.status   = ST_CLEARED;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("result %0d: %s expected %0h got %0h", replies_seen, field, want, got);
  endtask

  // one command transaction; predicts its result when the block takes it
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_H_W-1:0] kh,
                           input logic [KEY_L_W-1:0] kl, input logic [UNIT_W-1:0] unit,
                           input logic [AMT_W-1:0] amt, input logic [SLOT_W-1:0] rs);
    res_t r;
    if (gaps_on && burst_left <= 0) begin
      if (offering) begin
        in_tvalid <= 1'b0;
        offering = 1'b0;
      end
      repeat ($urandom_range(1, 45)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    in_tdata <= {3'b000, rs, amt, unit, kl, kh};
    in_tuser <= cmd;
    if (!offering) begin
      in_tvalid <= 1'b1;
      offering = 1'b1;
    end
    do @(posedge clk); while (!in_tready);
    burst_left--;
    if (tally_apply(cmd, kh, kl, unit, amt, rs, r)) replies_due.push_back(r);
    if (cmd != CMD_IGNORED) items_sent++;
  endtask

  // sender pauses until every predicted result has come back
  task automatic drain_replies();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_L_W-1:0] rand48();
    return KEY_L_W'(rand64());
  endfunction

  // result checker
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.slot   = out_tdata[4:0];
      got.total  = out_tdata[28:5];
      got.unit   = out_tdata[60:29];
      got.key_h  = out_tdata[124:61];
      got.key_l  = out_tdata[172:125];
      replies_seen++;
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected result, status", '0, 64'(got.status));
      end else begin
        want = replies_due.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 64'(want.status), 64'(got.status));
        if (got.slot !== want.slot)
          report_mismatch("slot", 64'(want.slot), 64'(got.slot));
        if (got.total !== want.total)
          report_mismatch("total", 64'(want.total), 64'(got.total));
        if (got.unit !== want.unit)
          report_mismatch("unit_out", 64'(want.unit), 64'(got.unit));
        if (got.key_h !== want.key_h) report_mismatch("key_high_out", want.key_h, got.key_h);
        if (got.key_l !== want.key_l)
          report_mismatch("key_low_out", 64'(want.key_l), 64'(got.key_l));
      end
    end
  end

  // receiver: changing stall patterns, plus long hold-offs on request
  initial begin : receiver
    rx_mode_t mode;
    int span;
    int hold_left;
    int hold_done;
    int phase;
    mode      = RX_STEADY;
    span      = 0;
    hold_left = 0;
    hold_done = 0;
    phase     = 0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (span <= 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          span = $urandom_range(20, 300);
        end
        span--;
        phase++;
        case (mode)
          RX_STEADY:   out_tready <= 1'b1;
          RX_COIN:     out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE:   out_tready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: out_tready <= (phase % 7) > 2;
          default:     out_tready <= 1'b1;
        endcase
      end
    end
  end

  // extremes, each command and each special case
  task automatic test_directed();
    logic [KEY_H_W-1:0] h1;
    logic [KEY_L_W-1:0] l1;
    h1 = '1;
    l1 = '1;
    send_item(CMD_READ, '0, '0, '0, '0, 5'd0);
    send_item(CMD_READ, '1, '1, '1, '1, 5'd31);
    send_item(CMD_ADD, '0, '0, '0, 16'd0, '0);
    send_item(CMD_ADD, '0, '0, '0, 16'd1, '0);
    send_item(CMD_ADD, h1, l1, '1, 16'hffff, '1);
    send_item(CMD_ADD, h1, l1, '0, 16'hffff, '0);
    // partial key matches must insert
    send_item(CMD_ADD, h1, '0, 32'h6b67_0000, 16'd5, '0);
    send_item(CMD_ADD, '0, l1, 32'h0000_6c62, 16'd7, '0);
    send_item(CMD_ADD, '0, '0, 32'h1234_5678, 16'hffff, '0);
    send_item(CMD_IGNORED, rand64(), rand48(), $urandom, 16'h00ff, 5'd1);
    for (int s = 0; s < 5; s++) send_item(CMD_READ, '0, '0, '0, '0, s[SLOT_W-1:0]);
    send_item(CMD_ADD, h1, '0, '1, 16'd0, '0);
    send_item(CMD_CLEAR, rand64(), rand48(), $urandom, 16'h8000, 5'd17);
    send_item(CMD_READ, '0, '0, '0, '0, 5'd0);
    send_item(CMD_ADD, h1, l1, 32'h6f7a_0000, 16'd3, '0);
    send_item(CMD_READ, '0, '0, '0, '0, 5'd0);
    send_item(CMD_CLEAR, '0, '0, '0, '0, '0);
    drain_replies();
  endtask

  // fill every slot, then a new key is dropped and old keys still sum
  task automatic test_table_full();
    logic [KEY_H_W-1:0] kh;
    logic [KEY_L_W-1:0] kl;
    for (int s = 0; s < SLOTS; s++) begin
      kh = rand64();
      kl = rand48();
      send_item(CMD_ADD, kh, kl, $urandom, AMT_W'($urandom_range(1, 16'hffff)), '0);
    end
    send_item(CMD_ADD, rand64(), rand48(), $urandom, 16'd9, '0);
    send_item(CMD_ADD, rand64(), rand48(), $urandom, 16'd0, '0);
    send_item(CMD_ADD, kh, kl, $urandom, 16'd11, '0);
    send_item(CMD_READ, '0, '0, '0, '0, 5'd31);
    send_item(CMD_READ, '0, '0, '0, '0, 5'd0);
    send_item(CMD_CLEAR, '0, '0, '0, '0, '0);
    drain_replies();
  endtask

  // one key summed past the 24-bit ceiling, with a second key alongside
  task automatic test_saturation();
    logic [KEY_H_W-1:0] kh;
    logic [KEY_L_W-1:0] kl;
    kh = rand64();
    kl = rand48();
    gaps_on = 1'b0;
    send_item(CMD_ADD, rand64(), rand48(), $urandom, 16'd1, '0);
    for (int i = 0; i < 280; i++) begin
      if (i == 140) gaps_on = 1'b1;
      send_item(CMD_ADD, kh, kl, $urandom,
                AMT_W'($urandom_range(16'hf000, 16'hffff)), '0);
    end
    send_item(CMD_READ, '0, '0, '0, '0, 5'd1);
    send_item(CMD_CLEAR, '0, '0, '0, '0, '0);
    drain_replies();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    logic [KEY_H_W-1:0] kh;
    logic [KEY_L_W-1:0] kl;
    kh = rand64();
    kl = rand48();
    gaps_on = 1'b0;
    hold_asked <= hold_asked + 1;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 2)
        send_item(CMD_READ, '0, '0, '0, '0, SLOT_W'($urandom_range(0, 3)));
      else
        send_item(CMD_ADD, (i % 2) ? kh : rand64(), kl, $urandom, AMT_W'($urandom), '0);
    end
    drain_replies();
    gaps_on = 1'b1;
  endtask

  // rounds over small key pools with random content and some noise
  task automatic test_random();
    logic [KEY_H_W-1:0] pool_h [$];
    logic [KEY_L_W-1:0] pool_l [$];
    logic [KEY_H_W-1:0] kh;
    logic [KEY_L_W-1:0] kl;
    logic [AMT_W-1:0]   amt;
    int target;
    int round_len;
    int pick;
    int n;
    target = items_sent + RANDOM_CNT;
    while (items_sent < target) begin
      pool_h.delete();
      pool_l.delete();
      n = $urandom_range(4, 48);
      for (int k = 0; k < n; k++) begin
        pick = $urandom_range(0, 99);
        kh = rand64();
        kl = rand48();
        if (k > 0 && pick < 15) kh = pool_h[k-1];
        else if (k > 0 && pick < 30) kl = pool_l[k-1];
        else if (pick < 35) begin
          kh = '0;
          kl = '0;
        end
        pool_h.push_back(kh);
        pool_l.push_back(kl);
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      round_len = $urandom_range(20, 120);
      for (int i = 0; i < round_len && items_sent < target; i++) begin
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
          0:       amt = '0;
          1:       amt = '1;
          default: amt = AMT_W'($urandom);
        endcase
        if (pick < 65) begin
          n = $urandom_range(0, pool_h.size() - 1);
          send_item(CMD_ADD, pool_h[n], pool_l[n], $urandom, amt, SLOT_W'($urandom));
        end else if (pick < 70) begin
          send_item(CMD_ADD, rand64(), rand48(), $urandom, amt, SLOT_W'($urandom));
        end else if (pick < 80) begin
          send_item(CMD_READ, rand64(), rand48(), $urandom, AMT_W'($urandom),
                    SLOT_W'($urandom_range(0, 31)));
        end else if (pick < 92) begin
          n = (tally_fill > 0) ? $urandom_range(0, tally_fill - 1) : 0;
          send_item(CMD_READ, '0, '0, '0, '0, n[SLOT_W-1:0]);
        end else if (pick < 96) begin
          send_item(CMD_CLEAR, rand64(), rand48(), $urandom, AMT_W'($urandom),
                    SLOT_W'($urandom));
        end else begin
          send_item(CMD_IGNORED, rand64(), rand48(), $urandom, AMT_W'($urandom),
                    SLOT_W'($urandom));
        end
      end
      if ($urandom_range(0, 1)) send_item(CMD_CLEAR, '0, '0, '0, '0, '0);
    end
    drain_replies();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_saturation();
    test_backpressure();
    test_random();
    drain_replies();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("keyed_sum_table: match");
    end else begin
      $display("keyed_sum_table: mismatch");
    end
    $finish;
  end

endmodule
